// ===== hdl/positional_pid_controller_assert.svh =====
// Assertion macros shared by the checker files of the PID controller.
// Needs clk and rst in the scope where a macro is used.
`ifndef POSITIONAL_PID_CONTROLLER_ASSERT_SVH
`define POSITIONAL_PID_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PPID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ppid_pkg.sv =====
// Shared constants, register indexes and types of the PID controller.
// No dependencies.
package ppid_pkg;

  localparam int DATA_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int ACC_WIDTH_DEF   = 32;
  localparam int GAIN_WIDTH      = 16;
  localparam int DRIVE_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SETPOINT = 2'd0,
    REG_KP       = 2'd1,
    REG_KI       = 2'd2,
    REG_KD       = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] kp;
    logic signed [GAIN_WIDTH-1:0] ki;
    logic signed [GAIN_WIDTH-1:0] kd;
  } gains_t;

endpackage

// ===== hdl/ppid_if.sv =====
// Channel interfaces of the PID controller: configuration, samples, results.
// Depends on ppid_pkg.
interface ppid_cfg_if #(
  parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF
);
  localparam int VALUE_WIDTH =
    (DATA_WIDTH > ppid_pkg::GAIN_WIDTH) ? DATA_WIDTH : ppid_pkg::GAIN_WIDTH;
  logic                                 valid;
  logic                                 ready;
  logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [VALUE_WIDTH-1:0]               value;
  modport source (output valid, index, value, input ready);
  modport sink   (input valid, index, value, output ready);
endinterface

interface ppid_sample_if #(
  parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;
  modport source (output valid, measurement, input ready);
  modport sink   (input valid, measurement, output ready);
endinterface

interface ppid_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ppid_pkg::DRIVE_WIDTH-1:0] drive;
  logic                                    saturated;
  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

// ===== hdl/ppid_front.sv =====
// Front end: configuration registers, error, saturating sum and error history.
// Depends on ppid_pkg and ppid_if.
module ppid_front #(
  parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ppid_pkg::ACC_WIDTH_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  ppid_cfg_if.sink                                               cfg,
  ppid_sample_if.sink                                            sample,
  output ppid_pkg::gains_t                                       gains,
  output logic                                                   push_valid,
  input  logic                                                   push_ready,
  output logic [1 + (DATA_WIDTH + 2) + ACC_WIDTH + (DATA_WIDTH + 1) - 1:0] push_data
);
  localparam int EW = DATA_WIDTH + 1;
  localparam int DW = DATA_WIDTH + 2;
  localparam int SW = ((ACC_WIDTH > EW) ? ACC_WIDTH : EW) + 1;
  localparam logic signed [SW-1:0] ACC_MAX = SW'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - SW'(1);

  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [ACC_WIDTH-1:0]  error_sum;
  logic signed [EW-1:0]         last_error;
  logic signed [EW-1:0]         older_error;

  logic signed [EW-1:0]         err;
  logic signed [SW-1:0]         sum_raw;
  logic signed [ACC_WIDTH-1:0]  sum_clip;
  logic                         sum_sat;
  logic signed [DW-1:0]         diff;
  logic                         take;

  assign cfg.ready    = 1'b1;
  assign sample.ready = push_ready;
  assign push_valid   = sample.valid;
  assign take         = sample.valid && push_ready;

  always_comb begin
    err = {setpoint[DATA_WIDTH-1], setpoint}
        - {sample.measurement[DATA_WIDTH-1], sample.measurement};
    sum_raw = SW'(error_sum) + SW'(err);
    sum_sat = 1'b1;
    if (sum_raw > ACC_MAX) begin
      sum_clip = ACC_MAX[ACC_WIDTH-1:0];
    end else if (sum_raw < ACC_MIN) begin
      sum_clip = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      sum_clip = sum_raw[ACC_WIDTH-1:0];
      sum_sat  = 1'b0;
    end
    diff = DW'(last_error) - DW'(older_error);
  end

  assign push_data = {sum_sat, diff, sum_clip, err};

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= '0;
      gains       <= '0;
      error_sum   <= '0;
      last_error  <= '0;
      older_error <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (ppid_pkg::reg_index_t'(cfg.index))
          ppid_pkg::REG_SETPOINT: setpoint <= cfg.value[DATA_WIDTH-1:0];
          ppid_pkg::REG_KP:       gains.kp <= cfg.value[ppid_pkg::GAIN_WIDTH-1:0];
          ppid_pkg::REG_KI:       gains.ki <= cfg.value[ppid_pkg::GAIN_WIDTH-1:0];
          ppid_pkg::REG_KD:       gains.kd <= cfg.value[ppid_pkg::GAIN_WIDTH-1:0];
        endcase
      end
      if (take) begin
        error_sum   <= sum_clip;
        older_error <= last_error;
        last_error  <= err;
      end
    end
  end

endmodule

// ===== hdl/ppid_queue.sv =====
// Small register FIFO between the front end and the arithmetic back end.
// Depends on nothing.
module ppid_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/ppid_back.sv =====
// Back end: gain products, sum, shift, output clip and the output register.
// Depends on ppid_pkg and ppid_if.
module ppid_back #(
  parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ppid_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH  = ppid_pkg::ACC_WIDTH_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  ppid_pkg::gains_t                                       gains,
  input  logic                                                   pop_valid,
  output logic                                                   pop_ready,
  input  logic [1 + (DATA_WIDTH + 2) + ACC_WIDTH + (DATA_WIDTH + 1) - 1:0] pop_data,
  ppid_result_if.source                                          result
);
  localparam int GW  = ppid_pkg::GAIN_WIDTH;
  localparam int EW  = DATA_WIDTH + 1;
  localparam int DW  = DATA_WIDTH + 2;
  localparam int PW  = GW + EW;
  localparam int IW  = GW + ACC_WIDTH;
  localparam int QW  = GW + DW;
  localparam int TW  = ((IW > QW) ? IW : QW) + 2;
  localparam int OW  = (TW > ppid_pkg::DRIVE_WIDTH + 1) ? TW : ppid_pkg::DRIVE_WIDTH + 1;
  localparam logic signed [OW-1:0] DRV_MAX = OW'(64'sd2147483647);
  localparam logic signed [OW-1:0] DRV_MIN = -DRV_MAX - OW'(1);

  logic signed [EW-1:0]        q_err;
  logic signed [ACC_WIDTH-1:0] q_sum;
  logic signed [DW-1:0]        q_diff;
  logic                        q_sat;
  logic                        en;

  logic                        v1;
  logic signed [PW-1:0]        prod_p;
  logic signed [IW-1:0]        prod_i;
  logic signed [QW-1:0]        prod_d;
  logic                        sat1;

  logic                        v2;
  logic signed [TW-1:0]        total;
  logic                        sat2;

  logic signed [TW-1:0]        shifted;
  logic signed [OW-1:0]        wide;
  logic signed [ppid_pkg::DRIVE_WIDTH-1:0] drive_next;
  logic                        drv_sat;

  assign q_err  = pop_data[EW-1:0];
  assign q_sum  = pop_data[EW +: ACC_WIDTH];
  assign q_diff = pop_data[EW + ACC_WIDTH +: DW];
  assign q_sat  = pop_data[EW + ACC_WIDTH + DW];

  assign en        = !result.valid || result.ready;
  assign pop_ready = en;

  always_comb begin
    shifted = total >>> FRAC_BITS;
    wide    = OW'(shifted);
    drv_sat = 1'b1;
    if (wide > DRV_MAX) begin
      drive_next = DRV_MAX[ppid_pkg::DRIVE_WIDTH-1:0];
    end else if (wide < DRV_MIN) begin
      drive_next = DRV_MIN[ppid_pkg::DRIVE_WIDTH-1:0];
    end else begin
      drive_next = wide[ppid_pkg::DRIVE_WIDTH-1:0];
      drv_sat    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_p           <= $signed(gains.kp) * q_err;
      prod_i           <= $signed(gains.ki) * q_sum;
      prod_d           <= $signed(gains.kd) * q_diff;
      sat1             <= q_sat;
      total            <= TW'(prod_p) + TW'(prod_i) + TW'(prod_d);
      sat2             <= sat1;
      result.drive     <= drive_next;
      result.saturated <= sat2 || drv_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      v1           <= pop_valid;
      v2           <= v1;
      result.valid <= v2;
    end
  end

endmodule

// ===== hdl/positional_pid_controller.sv =====
// Channel    | dir | word
// cfg        | in  | index (setpoint, kp, ki, kd), value
// sample     | in  | measurement
// result     | out | drive, saturated
//
// One sample per cycle sustained while the queue is not full.
// Registers: queue storage, three back-end ones (products, sum, clip); the queue read adds none.
// Synchronous reset clears gains, setpoint, the error sum and history, and all valids.
// A stalled result holds the back end; the 4-entry queue keeps the front taking samples until full.
// Depends on ppid_pkg, ppid_if, ppid_front, ppid_queue, ppid_back.
module positional_pid_controller #(
  parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ppid_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH  = ppid_pkg::ACC_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ppid_cfg_if.sink      cfg,
  ppid_sample_if.sink   sample,
  ppid_result_if.source result
);
  localparam int ENTRY_W = 1 + (DATA_WIDTH + 2) + ACC_WIDTH + (DATA_WIDTH + 1);

  ppid_pkg::gains_t   gains;
  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  ppid_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample     (sample),
    .gains      (gains),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ppid_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (ppid_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ppid_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

// ===== hdl/ppid_checker.sv =====
// Port-level checker of the PID controller and its bind to the top level.
// Depends on ppid_pkg and positional_pid_controller_assert.svh.
`include "positional_pid_controller_assert.svh"

module ppid_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ppid_pkg::DRIVE_WIDTH-1:0]    out_drive,
  input logic                                out_saturated
);
  localparam logic [7:0] PEND_MAX = 8'(ppid_pkg::QUEUE_DEPTH + 3);

  logic [7:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 8'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 8'd1;
    end
  end

  `PPID_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive) && $stable(out_saturated), "stalled result word changed")
  `PPID_ASSERT_IMP(a_no_orphan, out_valid, pending != 8'd0, "result word without a pending sample")
  `PPID_ASSERT_IMP(a_bounded, in_valid || out_valid, pending <= PEND_MAX, "more samples in flight than storage")
  `PPID_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind positional_pid_controller ppid_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready),
  .in_valid      (sample.valid),
  .in_ready      (sample.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_drive     (result.drive),
  .out_saturated (result.saturated)
);

// ===== verif/positional_pid_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for positional_pid_controller: directed and random samples, gain sets
// written between phases, a back-pressure run and a drive-clipping soak. Expected words
// come from a built-in model. Depends on ppid_pkg, ppid_if and the controller RTL.
module positional_pid_controller_tb;

  localparam longint SUM_MAX   = (longint'(1) <<< (ppid_pkg::ACC_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_MIN   = -SUM_MAX - 1;
  localparam longint DRIVE_MAX = (longint'(1) <<< (ppid_pkg::DRIVE_WIDTH - 1)) - 1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  typedef struct {
    logic signed [ppid_pkg::DRIVE_WIDTH-1:0] drive;
    logic                                    saturated;
  } drive_word_t;

  logic clk;
  logic rst;

  ppid_cfg_if    cfg_bus ();
  ppid_sample_if sample_bus ();
  ppid_result_if result_bus ();

  positional_pid_controller dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sample (sample_bus),
    .result (result_bus)
  );

  // controller model state
  logic signed [ppid_pkg::DATA_WIDTH_DEF-1:0] sp_reg;
  logic signed [ppid_pkg::GAIN_WIDTH-1:0]     kp_reg;
  logic signed [ppid_pkg::GAIN_WIDTH-1:0]     ki_reg;
  logic signed [ppid_pkg::GAIN_WIDTH-1:0]     kd_reg;
  longint                                     sum_state;
  logic signed [ppid_pkg::DATA_WIDTH_DEF:0]   last_err;
  logic signed [ppid_pkg::DATA_WIDTH_DEF:0]   older_err;

  drive_word_t expected_drive_q[$];
  int          error_count;

  int burst_left;
  bit tx_no_gaps;
  bit rx_always_ready;
  int hold_request;
  int hold_left;
  int rx_seg_left;
  int rx_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic drive_word_t predict_drive(
      input logic signed [ppid_pkg::DATA_WIDTH_DEF-1:0] meas);
    drive_word_t w;
    longint err, sum, diff, total, drv;
    w.saturated = 1'b0;
    err = longint'(sp_reg) - longint'(meas);
    sum = sum_state + err;
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
      w.saturated = 1'b1;
    end else if (sum < SUM_MIN) begin
      sum = SUM_MIN;
      w.saturated = 1'b1;
    end
    sum_state = sum;
    diff = longint'(last_err) - longint'(older_err);
    older_err = last_err;
    last_err = err[ppid_pkg::DATA_WIDTH_DEF:0];
    total = longint'(kp_reg) * err + longint'(ki_reg) * sum + longint'(kd_reg) * diff;
    drv = total >>> ppid_pkg::FRAC_BITS_DEF;
    if (drv > DRIVE_MAX) begin
      drv = DRIVE_MAX;
      w.saturated = 1'b1;
    end else if (drv < DRIVE_MIN) begin
      drv = DRIVE_MIN;
      w.saturated = 1'b1;
    end
    w.drive = drv[ppid_pkg::DRIVE_WIDTH-1:0];
    return w;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  // result checker
  always @(posedge clk) begin
    drive_word_t exp_w;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_drive_q.size() == 0) begin
        flag_error($sformatf("unexpected word drive=%0d saturated=%0b",
                             result_bus.drive, result_bus.saturated));
      end else begin
        exp_w = expected_drive_q.pop_front();
        if (result_bus.drive !== exp_w.drive)
          flag_error($sformatf("drive expected %0d got %0d", exp_w.drive, result_bus.drive));
        if (result_bus.saturated !== exp_w.saturated)
          flag_error($sformatf("saturated expected %0b got %0b (drive %0d)",
                               exp_w.saturated, result_bus.saturated, exp_w.drive));
      end
    end
  end

  // receiver stall pattern, plus long hold-offs on request
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (rx_seg_left == 0) begin
        rx_seg_left = $urandom_range(4, 64);
        rx_mode = $urandom_range(0, 3);
      end
      rx_seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (rx_always_ready || rx_mode == 0) begin
        result_bus.ready <= 1'b1;
      end else if (rx_mode == 1) begin
        result_bus.ready <= ($urandom_range(0, 3) != 0);
      end else if (rx_mode == 2) begin
        result_bus.ready <= ($urandom_range(0, 3) == 0);
      end else begin
        result_bus.ready <= rx_seg_left[0];
      end
    end
  end

  task automatic send_sample(input logic signed [ppid_pkg::DATA_WIDTH_DEF-1:0] meas);
    if (!tx_no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        sample_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    sample_bus.valid       <= 1'b1;
    sample_bus.measurement <= meas;
    do @(posedge clk); while (!sample_bus.ready);
    expected_drive_q.push_back(predict_drive(meas));
  endtask

  task automatic write_reg(input ppid_pkg::reg_index_t idx,
                           input logic [ppid_pkg::GAIN_WIDTH-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.value <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      ppid_pkg::REG_SETPOINT: sp_reg = val;
      ppid_pkg::REG_KP:       kp_reg = val;
      ppid_pkg::REG_KI:       ki_reg = val;
      ppid_pkg::REG_KD:       kd_reg = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_gains(input logic [15:0] sp, input logic [15:0] kp,
                             input logic [15:0] ki, input logic [15:0] kd);
    write_reg(ppid_pkg::REG_SETPOINT, sp);
    write_reg(ppid_pkg::REG_KP, kp);
    write_reg(ppid_pkg::REG_KI, ki);
    write_reg(ppid_pkg::REG_KD, kd);
  endtask

  task automatic await_idle();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(input int kind);
    logic [15:0] extremes[5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
    case (kind)
      0:       return 16'($urandom);
      1:       return extremes[$urandom_range(0, 4)];
      default: return 16'($urandom_range(0, 16'h0400) - 16'h0200);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_measurement();
    logic signed [15:0] extremes[4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 16'(int'(sp_reg) + int'($urandom_range(0, 128)) - 64);
    if (roll < 8) return 16'($urandom);
    return extremes[$urandom_range(0, 3)];
  endfunction

  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
  endtask

  task automatic test_proportional();
    await_idle();
    write_gains(16'h0000, 16'h0100, 16'h0000, 16'h0000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    await_idle();
    // 1/256 gain: negative totals round toward minus infinity
    write_reg(ppid_pkg::REG_KP, 16'h0001);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh8000);
    await_idle();
    write_reg(ppid_pkg::REG_KP, 16'h8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
  endtask

  task automatic test_integral_derivative();
    await_idle();
    write_gains(16'h7FFF, 16'h0000, 16'h0001, 16'h0000);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    await_idle();
    // derivative lags one sample behind the current error
    write_gains(16'h8000, 16'h0000, 16'h0000, 16'h7FFF);
    send_sample(16'sh0064);
    send_sample(16'shFF38);
    send_sample(16'sh012C);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
  endtask

  task automatic test_random_phases();
    int kind;
    for (int phase = 0; phase < 8; phase++) begin
      await_idle();
      kind = (phase < 3) ? phase : $urandom_range(0, 2);
      write_gains(pick_value(kind), pick_value(kind), pick_value(kind), pick_value(kind));
      for (int i = 0; i < 25; i++) send_sample(pick_measurement());
    end
  endtask

  task automatic test_backpressure();
    await_idle();
    write_gains(pick_value(0), pick_value(2), pick_value(2), pick_value(2));
    tx_no_gaps = 1'b1;
    hold_request = 80;
    for (int i = 0; i < 40; i++) send_sample(pick_measurement());
    tx_no_gaps = 1'b0;
  endtask

  task automatic test_drive_clipping();
    await_idle();
    tx_no_gaps = 1'b1;
    rx_always_ready = 1'b1;
    // full-scale error with the largest ki drives the output past the top after ~257 samples
    write_gains(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
    repeat (264) send_sample(16'sh8000);
    await_idle();
    write_reg(ppid_pkg::REG_KI, 16'h8000);
    repeat (4) send_sample(16'($urandom));
    tx_no_gaps = 1'b0;
    rx_always_ready = 1'b0;
  endtask

  initial begin
    sp_reg = '0;
    kp_reg = '0;
    ki_reg = '0;
    kd_reg = '0;
    sum_state = 0;
    last_err = '0;
    older_err = '0;
    error_count = 0;
    burst_left = 0;
    tx_no_gaps = 1'b0;
    rx_always_ready = 1'b0;
    hold_request = 0;
    hold_left = 0;
    rx_seg_left = 0;
    rx_mode = 0;
    rst <= 1'b1;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= ppid_pkg::REG_SETPOINT;
    cfg_bus.value <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.measurement <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_proportional();
    test_integral_derivative();
    test_random_phases();
    test_backpressure();
    test_drive_clipping();
    await_idle();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ppid_pkg.sv
hdl/ppid_if.sv
hdl/ppid_front.sv
hdl/ppid_queue.sv
hdl/ppid_back.sv
hdl/positional_pid_controller.sv
hdl/ppid_checker.sv
verif/positional_pid_controller_tb.sv
